// ===== hdl/multi_pattern_dictionary_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Multi-pattern dictionary matcher: assertion macros
// Immediate-consequence and next-cycle property wrappers on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_DICTIONARY_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_DICTIONARY_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define MPDM_CHECK_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpdm check failed");
`define MPDM_CHECK_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpdm check failed");
`else
`define MPDM_CHECK_IMP(label, ante, cons)
`define MPDM_CHECK_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/mpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpdm_pkg
// Shared types and codes for the dictionary matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpdm_pkg;

    localparam int MODE_W = 2;
    localparam int SYM_W  = 5;
    localparam int WIDX_W = 10;

    typedef enum logic [MODE_W-1:0] {
        MODE_PATTERN = 2'd0,
        MODE_END     = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_INS_CHK,
        ST_QRY,
        ST_BFS_RD,
        ST_BFS_CHK,
        ST_BFS_NXT,
        ST_BFS_DQ,
        ST_BFS_U,
        ST_BFS_SU,
        ST_GO_RD,
        ST_GO_CHK,
        ST_GO_SL,
        ST_OUT_RD,
        ST_OUT_CHK
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic [SYM_W-1:0]   symbol;
        logic [WIDX_W-1:0]  word_index;
    } item_t;

    typedef struct packed {
        logic valid;
        logic word_found;
        logic table_full;
    } result_t;

endpackage

// ===== hdl/mpdm_engine.sv =====
// ----------------------------------------------------------------------------
// mpdm_engine
// Trie, link and flag memories with the sequencer that inserts, rebuilds
// suffix links breadth-first, walks text and answers queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_pattern_dictionary_matcher_defines.svh"

module mpdm_engine
    import mpdm_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26,
    parameter int MAX_WORDS = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output result_t result
);

    localparam int CD   = MAX_NODES * ALPHABET;
    localparam int CAW  = $clog2(CD);
    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int WW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW  = $clog2(MAX_WORDS + 1);

    state_t state_reg, state_next;

    logic [CAW-1:0]    clr_reg, clr_next;
    mode_t             mode_reg, mode_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [NCW-1:0]    nc_reg, nc_next;
    logic [NW-1:0]     ins_reg, ins_next;
    logic [NW-1:0]     match_reg, match_next;
    logic [WCW-1:0]    wc_reg, wc_next;
    logic              ovf_reg, ovf_next;
    logic              trunc_reg, trunc_next;
    logic              stale_reg, stale_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [SYM_W-1:0]  gc_reg, gc_next;
    logic              gret_reg, gret_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [SYM_W-1:0]  c_reg, c_next;
    logic [NW-1:0]     w_reg, w_next;
    logic [NW-1:0]     su_reg, su_next;
    logic [NW-1:0]     head_reg, head_next;
    logic [NW-1:0]     tail_reg, tail_next;
    logic [NW-1:0]     k_reg, k_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_found_reg, res_found_next;

    logic [NW-1:0] child_mem [CD];
    logic [NW-1:0] sfx_mem   [MAX_NODES];
    logic          tmark_mem [MAX_NODES];
    logic [WW-1:0] tword_mem [MAX_NODES];
    logic          found_mem [MAX_WORDS];
    logic [NW-1:0] queue_mem [MAX_NODES];

    logic           child_we;
    logic [CAW-1:0] child_wa, child_ra;
    logic [NW-1:0]  child_wd, child_rd;
    logic           sfx_we;
    logic [NW-1:0]  sfx_wa, sfx_ra, sfx_wd, sfx_rd;
    logic           tmark_we, tmark_wd, tmark_rd;
    logic [NW-1:0]  tmark_wa, tmark_ra;
    logic           tword_we;
    logic [WW-1:0]  tword_wd, tword_rd;
    logic           found_we, found_wd, found_rd;
    logic [WW-1:0]  found_wa, found_ra;
    logic           queue_we;
    logic [NW-1:0]  queue_wa, queue_wd, queue_ra, queue_rd;

    logic [WW-1:0]  qidx;
    logic           q_in_range;
    logic           sym_ok;

    assign qidx       = WW'(widx_reg);
    assign q_in_range = 32'(widx_reg) < MAX_WORDS;
    assign sym_ok     = 32'(sym_reg) < ALPHABET;

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_wa] <= child_wd;
        end
        child_rd <= child_mem[child_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sfx_we)
        begin
            sfx_mem[sfx_wa] <= sfx_wd;
        end
        sfx_rd <= sfx_mem[sfx_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tmark_we)
        begin
            tmark_mem[tmark_wa] <= tmark_wd;
        end
        tmark_rd <= tmark_mem[tmark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tword_we)
        begin
            tword_mem[ins_reg] <= tword_wd;
        end
        tword_rd <= tword_mem[tmark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (found_we)
        begin
            found_mem[found_wa] <= found_wd;
        end
        found_rd <= found_mem[found_ra];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_rd <= queue_mem[queue_ra];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CAW'(CD - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (mode_reg)
                    MODE_PATTERN: state_next = (sym_ok && !trunc_reg) ? ST_INS_CHK : ST_IDLE;
                    MODE_END:     state_next = ST_IDLE;
                    MODE_TEXT:
                    begin
                        if (!sym_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = stale_reg ? ST_BFS_RD : ST_GO_RD;
                        end
                    end
                    default:      state_next = ST_QRY;
                endcase
            end
            ST_INS_CHK: state_next = ST_IDLE;
            ST_QRY:     state_next = ST_IDLE;
            ST_BFS_RD:  state_next = ST_BFS_CHK;
            ST_BFS_CHK:
            begin
                if (child_rd != '0 && u_reg != '0)
                begin
                    state_next = ST_GO_RD;
                end
                else
                begin
                    state_next = ST_BFS_NXT;
                end
            end
            ST_BFS_NXT:
            begin
                if (32'(c_reg) != ALPHABET - 1)
                begin
                    state_next = ST_BFS_RD;
                end
                else if (head_reg == tail_reg)
                begin
                    state_next = ST_GO_RD;
                end
                else
                begin
                    state_next = ST_BFS_DQ;
                end
            end
            ST_BFS_DQ:  state_next = ST_BFS_U;
            ST_BFS_U:   state_next = ST_BFS_SU;
            ST_BFS_SU:  state_next = ST_BFS_RD;
            ST_GO_RD:   state_next = ST_GO_CHK;
            ST_GO_CHK:
            begin
                if (child_rd != '0 || v_reg == '0)
                begin
                    state_next = gret_reg ? ST_BFS_NXT : ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_GO_SL;
                end
            end
            ST_GO_SL:   state_next = ST_GO_RD;
            ST_OUT_RD:  state_next = ST_OUT_CHK;
            ST_OUT_CHK: state_next = (k_reg == '0) ? ST_IDLE : ST_OUT_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        sym_next       = sym_reg;
        widx_next      = widx_reg;
        nc_next        = nc_reg;
        ins_next       = ins_reg;
        match_next     = match_reg;
        wc_next        = wc_reg;
        ovf_next       = ovf_reg;
        trunc_next     = trunc_reg;
        stale_next     = stale_reg;
        v_next         = v_reg;
        gc_next        = gc_reg;
        gret_next      = gret_reg;
        u_next         = u_reg;
        c_next         = c_reg;
        w_next         = w_reg;
        su_next        = su_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        k_next         = k_reg;
        res_valid_next = 1'b0;
        res_found_next = res_found_reg;

        child_we = 1'b0;
        child_wa = CAW'(CAW'(ins_reg) * CAW'(ALPHABET) + CAW'(sym_reg));
        child_wd = NW'(nc_reg);
        child_ra = CAW'(CAW'(ins_reg) * CAW'(ALPHABET) + CAW'(sym_reg));
        sfx_we   = 1'b0;
        sfx_wa   = w_reg;
        sfx_wd   = '0;
        sfx_ra   = v_reg;
        tmark_we = 1'b0;
        tmark_wa = ins_reg;
        tmark_wd = 1'b1;
        tmark_ra = k_reg;
        tword_we = 1'b0;
        tword_wd = WW'(wc_reg);
        found_we = 1'b0;
        found_wa = tword_rd;
        found_wd = 1'b1;
        found_ra = qidx;
        queue_we = 1'b0;
        queue_wa = tail_reg;
        queue_wd = child_rd;
        queue_ra = head_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                child_we = 1'b1;
                child_wa = clr_reg;
                child_wd = '0;
                tmark_we = 32'(clr_reg) < MAX_NODES;
                tmark_wa = NW'(clr_reg);
                tmark_wd = 1'b0;
                found_we = 32'(clr_reg) < MAX_WORDS;
                found_wa = WW'(clr_reg);
                found_wd = 1'b0;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = item.mode;
                    sym_next  = item.symbol;
                    widx_next = item.word_index;
                end
            end
            ST_DISP:
            begin
                case (mode_reg)
                    MODE_PATTERN:
                    begin
                    end
                    MODE_END:
                    begin
                        if (32'(wc_reg) < MAX_WORDS)
                        begin
                            tmark_we = !trunc_reg;
                            tword_we = !trunc_reg;
                            wc_next  = wc_reg + 1'b1;
                        end
                        ins_next   = '0;
                        trunc_next = 1'b0;
                    end
                    MODE_TEXT:
                    begin
                        if (!sym_ok)
                        begin
                            match_next = '0;
                        end
                        else if (stale_reg)
                        begin
                            sfx_we    = 1'b1;
                            sfx_wa    = '0;
                            sfx_wd    = '0;
                            u_next    = '0;
                            c_next    = '0;
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            v_next    = match_reg;
                            gc_next   = sym_reg;
                            gret_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_INS_CHK:
            begin
                if (child_rd != '0)
                begin
                    ins_next = child_rd;
                end
                else if (nc_reg >= NCW'(MAX_NODES))
                begin
                    ovf_next   = 1'b1;
                    trunc_next = 1'b1;
                end
                else
                begin
                    child_we   = 1'b1;
                    ins_next   = NW'(nc_reg);
                    nc_next    = nc_reg + 1'b1;
                    stale_next = 1'b1;
                end
            end
            ST_QRY:
            begin
                res_valid_next = 1'b1;
                res_found_next = q_in_range & found_rd;
            end
            ST_BFS_RD:
            begin
                child_ra = CAW'(CAW'(u_reg) * CAW'(ALPHABET) + CAW'(c_reg));
            end
            ST_BFS_CHK:
            begin
                w_next = child_rd;
                if (child_rd != '0)
                begin
                    queue_we  = 1'b1;
                    tail_next = tail_reg + 1'b1;
                    if (u_reg == '0)
                    begin
                        sfx_we = 1'b1;
                        sfx_wa = child_rd;
                        sfx_wd = '0;
                    end
                    else
                    begin
                        v_next    = su_reg;
                        gc_next   = c_reg;
                        gret_next = 1'b1;
                    end
                end
            end
            ST_BFS_NXT:
            begin
                if (32'(c_reg) != ALPHABET - 1)
                begin
                    c_next = c_reg + 1'b1;
                end
                else if (head_reg == tail_reg)
                begin
                    stale_next = 1'b0;
                    v_next     = match_reg;
                    gc_next    = sym_reg;
                    gret_next  = 1'b0;
                end
            end
            ST_BFS_DQ:
            begin
                head_next = head_reg + 1'b1;
            end
            ST_BFS_U:
            begin
                u_next = queue_rd;
                sfx_ra = queue_rd;
            end
            ST_BFS_SU:
            begin
                su_next = sfx_rd;
                c_next  = '0;
            end
            ST_GO_RD:
            begin
                child_ra = CAW'(CAW'(v_reg) * CAW'(ALPHABET) + CAW'(gc_reg));
            end
            ST_GO_CHK:
            begin
                if (child_rd != '0 || v_reg == '0)
                begin
                    if (gret_reg)
                    begin
                        sfx_we = 1'b1;
                        sfx_wa = w_reg;
                        sfx_wd = child_rd;
                    end
                    else
                    begin
                        match_next = child_rd;
                        k_next     = child_rd;
                    end
                end
                else
                begin
                    sfx_ra = v_reg;
                end
            end
            ST_GO_SL:
            begin
                v_next = sfx_rd;
            end
            ST_OUT_RD:
            begin
                tmark_ra = k_reg;
                sfx_ra   = k_reg;
            end
            ST_OUT_CHK:
            begin
                found_we = tmark_rd;
                if (k_reg != '0)
                begin
                    k_next = sfx_rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            nc_reg        <= NCW'(1);
            ins_reg       <= '0;
            match_reg     <= '0;
            wc_reg        <= '0;
            ovf_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            stale_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            nc_reg        <= nc_next;
            ins_reg       <= ins_next;
            match_reg     <= match_next;
            wc_reg        <= wc_next;
            ovf_reg       <= ovf_next;
            trunc_reg     <= trunc_next;
            stale_reg     <= stale_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        sym_reg       <= sym_next;
        widx_reg      <= widx_next;
        v_reg         <= v_next;
        gc_reg        <= gc_next;
        gret_reg      <= gret_next;
        u_reg         <= u_next;
        c_reg         <= c_next;
        w_reg         <= w_next;
        su_reg        <= su_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        k_reg         <= k_next;
        res_found_reg <= res_found_next;
    end

    assign busy              = (state_reg != ST_IDLE);
    assign result.valid      = res_valid_reg;
    assign result.word_found = res_found_reg;
    assign result.table_full = ovf_reg;

    `MPDM_CHECK_IMP(a_start_idle, start, state_reg == ST_IDLE)
    `MPDM_CHECK_IMP(a_nc_bound, 1'b1, nc_reg <= NCW'(MAX_NODES))
    `MPDM_CHECK_IMP(a_ins_bound, 1'b1, NCW'(ins_reg) < nc_reg)
    `MPDM_CHECK_NXT(a_res_after_qry, state_reg == ST_QRY, res_valid_reg)
    `MPDM_CHECK_IMP(a_res_idle, res_valid_reg, state_reg == ST_IDLE)

endmodule

// ===== hdl/multi_pattern_dictionary_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_dictionary_matcher
// Aho-Corasick dictionary matcher: trie load, text scan and found queries.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   mode, symbol, word_index
//   out      source     out_valid / out_stall word_found, table_full
//
// After reset a clearing pass walks the child table, MAX_NODES*ALPHABET
// entries (106496 at defaults), with in_stall high.
// Pattern symbols pass dispatch and a child check; end of word, dispatch only;
// a query, dispatch and the found-flag read. A text symbol follows suffix links
// while seeking a child, then walks the output chain down to the root; a rebuild
// of links, when words changed, reads each child-table slot of every node plus
// the goto walk for each child, all on the one child port.
// in_stall rises while an item is in work, a result is on its way to the
// output register or an unaccepted result holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_pattern_dictionary_matcher
    import mpdm_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26,
    parameter int MAX_WORDS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [WIDX_W-1:0] word_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              word_found,
    output logic              table_full
);

    logic    start;
    logic    busy;
    item_t   item;
    result_t result;

    logic out_valid_reg, out_valid_next;
    logic found_reg, found_next;
    logic full_reg, full_next;

    assign in_stall        = busy || result.valid || (out_valid_reg && out_stall);
    assign start           = in_valid && !in_stall;
    assign item.mode       = mode_t'(mode);
    assign item.symbol     = symbol;
    assign item.word_index = word_index;

    mpdm_engine #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET),
        .MAX_WORDS (MAX_WORDS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
            found_next     = result.word_found;
            full_next      = result.table_full;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        full_reg  <= full_next;
    end

    assign out_valid  = out_valid_reg;
    assign word_found = found_reg;
    assign table_full = full_reg;

endmodule

// ===== sim/tb_multi_pattern_dictionary_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_multi_pattern_dictionary_matcher
// Self-checking bench for the dictionary matcher. A directed table covers the
// special cases: empty word, identical words and out-of-range symbols. Random
// phases follow, each loading a few words and then scanning text and querying.
// Query results are checked against an in-bench automaton, or against the values the directed table gives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_pattern_dictionary_matcher;
    import mpdm_pkg::*;

    localparam int NODES = 4096;
    localparam int ALPH  = 26;
    localparam int WORDS = 1024;
    localparam longint LIMIT = 3000000;

    typedef struct {
        mode_t            mode;
        logic [SYM_W-1:0] sym;
        logic [9:0]       widx;
        bit               typed;
        bit               ef;
        bit               et;
    } row_t;

    typedef struct {
        bit found;
        bit full;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [WIDX_W-1:0] word_index;
    logic              out_valid;
    logic              out_stall;
    logic              word_found;
    logic              table_full;

    int unsigned kid   [NODES*ALPH];
    int unsigned sfx   [NODES];
    int unsigned par   [NODES];
    int unsigned plet  [NODES];
    bit          term  [NODES];
    int unsigned tword [NODES];
    bit          hit   [WORDS];
    int unsigned nodes_used, ins_at, scan_at, words_used;
    bit          full_seen, trunc, stale;

    answer_t answers_due[$];
    row_t    plan [25];
    int      errors;
    int      burst_left;
    int      stall_pct;
    longint  cycles;

    multi_pattern_dictionary_matcher DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .symbol     (symbol),
        .word_index (word_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_found (word_found),
        .table_full (table_full)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned next_state(int unsigned v, int unsigned c);
        int unsigned guard;
        guard = 0;
        while (v != 0 && kid[v*ALPH+c] == 0 && guard < NODES)
        begin
            v = sfx[v];
            guard++;
        end
        return kid[v*ALPH+c];
    endfunction

    function automatic void rebuild_links();
        int unsigned fifo [$];
        int unsigned u, w;
        sfx[0] = 0;
        fifo.push_back(0);
        while (fifo.size() != 0)
        begin
            u = fifo.pop_front();
            for (int c = 0; c < ALPH; c++)
            begin
                w = kid[u*ALPH+c];
                if (w != 0)
                begin
                    sfx[w] = (u == 0) ? 0 : next_state(sfx[par[w]], plet[w]);
                    fifo.push_back(w);
                end
            end
        end
        stale = 1'b0;
    endfunction

    // Updates the automaton; returns 1 with the answer for a query.
    function automatic bit match_step(mode_t m, int unsigned s, int unsigned w,
                                      output answer_t ans);
        int unsigned k, guard;
        ans = '{0, 0};
        case (m)
            MODE_PATTERN:
            begin
                if (s >= ALPH || trunc)
                    return 0;
                if (kid[ins_at*ALPH+s] == 0)
                begin
                    if (nodes_used >= NODES)
                    begin
                        full_seen = 1'b1;
                        trunc = 1'b1;
                        return 0;
                    end
                    par[nodes_used] = ins_at;
                    plet[nodes_used] = s;
                    kid[ins_at*ALPH+s] = nodes_used;
                    nodes_used++;
                    stale = 1'b1;
                end
                ins_at = kid[ins_at*ALPH+s];
                return 0;
            end
            MODE_END:
            begin
                if (words_used < WORDS)
                begin
                    if (!trunc)
                    begin
                        term[ins_at] = 1'b1;
                        tword[ins_at] = words_used;
                    end
                    words_used++;
                end
                ins_at = 0;
                trunc = 1'b0;
                return 0;
            end
            MODE_TEXT:
            begin
                if (s >= ALPH)
                begin
                    scan_at = 0;
                    return 0;
                end
                if (stale)
                    rebuild_links();
                scan_at = next_state(scan_at, s);
                k = scan_at;
                guard = 0;
                forever
                begin
                    if (term[k] && tword[k] < WORDS)
                        hit[tword[k]] = 1'b1;
                    if (k == 0 || guard >= NODES)
                        break;
                    k = sfx[k];
                    guard++;
                end
                return 0;
            end
            default:
            begin
                ans.found = (w < WORDS) ? hit[w] : 1'b0;
                ans.full = full_seen;
                return 1;
            end
        endcase
    endfunction

    task automatic send_item(input mode_t m, input logic [SYM_W-1:0] s,
                             input logic [WIDX_W-1:0] w, input bit typed = 0,
                             input bit ef = 0, input bit et = 0);
        answer_t ans;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= m;
        symbol     <= s;
        word_index <= w;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (match_step(m, s, w, ans))
        begin
            if (typed)
                ans = '{ef, et};
            answers_due.push_back(ans);
        end
    endtask

    always @(negedge clk)
    begin
        if (cycles % 128 == 0)
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        answer_t due;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                due = answers_due.pop_front();
                if (word_found !== due.found)
                begin
                    $error("word_found expected %0d actual %0d", due.found, word_found);
                    errors++;
                end
                if (table_full !== due.full)
                begin
                    $error("table_full expected %0d actual %0d", due.full, table_full);
                    errors++;
                end
            end
        end
    end

    task automatic random_word(input int len, input int span);
        for (int i = 0; i < len; i++)
            send_item(MODE_PATTERN, SYM_W'($urandom_range(0, span)), WIDX_W'($urandom));
        send_item(MODE_END, SYM_W'($urandom), WIDX_W'($urandom));
    endtask

    initial
    begin
        cycles = 0;
        errors = 0;
        burst_left = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_PATTERN;
        symbol = '0;
        word_index = '0;
        out_stall = 1'b0;
        foreach (kid[i]) kid[i] = 0;
        for (int i = 0; i < NODES; i++)
        begin
            sfx[i] = 0;
            par[i] = 0;
            plet[i] = 0;
            term[i] = 1'b0;
            tword[i] = 0;
        end
        foreach (hit[i]) hit[i] = 1'b0;
        nodes_used = 1;
        ins_at = 0;
        scan_at = 0;
        words_used = 0;
        full_seen = 1'b0;
        trunc = 1'b0;
        stale = 1'b0;

        // h=7 e=4 s=18
        plan = '{
            '{MODE_QUERY,   5'd0,  10'd0,    1, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd1023, 1, 0, 0},
            '{MODE_PATTERN, 5'd31, 10'd0,    0, 0, 0},
            '{MODE_END,     5'd0,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd7,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd4,  10'd0,    0, 0, 0},
            '{MODE_END,     5'd0,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd18, 10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd7,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd4,  10'd0,    0, 0, 0},
            '{MODE_END,     5'd0,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd7,  10'd0,    0, 0, 0},
            '{MODE_PATTERN, 5'd4,  10'd0,    0, 0, 0},
            '{MODE_END,     5'd0,  10'd0,    0, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd0,    1, 0, 0},
            '{MODE_TEXT,    5'd26, 10'd0,    0, 0, 0},
            '{MODE_TEXT,    5'd31, 10'd0,    0, 0, 0},
            '{MODE_TEXT,    5'd18, 10'd0,    0, 0, 0},
            '{MODE_TEXT,    5'd7,  10'd0,    0, 0, 0},
            '{MODE_TEXT,    5'd4,  10'd0,    0, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd0,    0, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd1,    1, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd2,    0, 0, 0},
            '{MODE_QUERY,   5'd0,  10'd3,    0, 0, 0},
            '{MODE_TEXT,    5'd0,  10'd0,    0, 0, 0}
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].mode, plan[i].sym, plan[i].widx,
                      plan[i].typed, plan[i].ef, plan[i].et);

        for (int ph = 0; ph < 25; ph++)
        begin
            repeat ($urandom_range(1, 4))
                random_word($urandom_range(0, 5), $urandom_range(1, 4));
            for (int i = 0; i < 70; i++)
                case ($urandom_range(0, 9))
                    0: send_item(MODE_QUERY, SYM_W'($urandom),
                                 WIDX_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                                   : $urandom_range(0, words_used)));
                    1: send_item(mode_t'($urandom_range(0, 3)), SYM_W'($urandom),
                                 WIDX_W'($urandom));
                    default: send_item(MODE_TEXT,
                                       SYM_W'($urandom_range(0, 19) == 0 ? $urandom
                                                                         : $urandom_range(0, 4)),
                                       WIDX_W'($urandom));
                endcase
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
